>>> hw/rtl/mbe_pkg.sv
// Shared types and constants for the escape-time evaluator.
package mbe_pkg;

    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned NUM_W     = 32;
    localparam int unsigned PROD_W    = 2 * NUM_W;
    localparam int unsigned SQ_W      = PROD_W - 1 - FRAC_BITS;
    localparam int unsigned RI_W      = PROD_W - FRAC_BITS;
    localparam int unsigned ACC_W     = 40;
    localparam int unsigned MAG_W     = SQ_W + 2;
    localparam int unsigned MAP_W     = 45;

    localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(4) << FRAC_BITS;

    typedef enum logic [2:0] {
        CFG_CENTER_RE = 3'd0,
        CFG_CENTER_IM = 3'd1,
        CFG_PIXEL_STEP = 3'd2,
        CFG_MAX_ITER  = 3'd3,
        CFG_IMG_W     = 3'd4,
        CFG_IMG_H     = 3'd5
    } cfg_idx_t;

    localparam logic [30:0] RST_PIXEL_STEP = 31'd1342177;
    localparam logic [15:0] RST_MAX_ITER   = 16'd1000;
    localparam logic [10:0] RST_IMG_W      = 11'd800;
    localparam logic [10:0] RST_IMG_H      = 11'd600;

    typedef struct packed {
        logic signed [31:0] center_re;
        logic signed [31:0] center_im;
        logic [30:0]        pixel_step;
        logic [15:0]        iter_limit;
        logic [10:0]        image_width;
        logic [10:0]        image_height;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_RE,
        ST_MAP_IM,
        ST_MAP_END,
        ST_MUL_RI,
        ST_STEP,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_MAG,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/mbe_cfg_regs.sv
// Configuration register file for the escape-time evaluator.
module mbe_cfg_regs
    import mbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_re      <= '0;
            cfg_reg.center_im      <= '0;
            cfg_reg.pixel_step     <= RST_PIXEL_STEP;
            cfg_reg.iter_limit     <= RST_MAX_ITER;
            cfg_reg.image_width    <= RST_IMG_W;
            cfg_reg.image_height   <= RST_IMG_H;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_RE:  cfg_reg.center_re      <= $signed(cfg_data);
                CFG_CENTER_IM:  cfg_reg.center_im      <= $signed(cfg_data);
                CFG_PIXEL_STEP: cfg_reg.pixel_step     <= cfg_data[30:0];
                CFG_MAX_ITER:   cfg_reg.iter_limit     <= cfg_data[15:0];
                CFG_IMG_W:      cfg_reg.image_width    <= cfg_data[10:0];
                CFG_IMG_H:      cfg_reg.image_height   <= cfg_data[10:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/mandelbrot_escape_time.sv
// Escape-time evaluator: pixel to complex point, then z = z*z + c iteration.
//
//   channel  dir  word
//   s_*      in   pixel_x [9:0], pixel_y [19:10]
//   m_*      out  iteration_count [15:0], escaped [16]
//   cfg_*    in   register write, index 0..5
//
// One 32x32 signed multiplier, registered, shared by every product.
// A pixel runs at most the iteration limit of iterations and ends early on escape,
// either on overflow in the update or when the magnitude check exceeds the limit.
// Per iteration: three multiplier passes, one update step, one magnitude check.
// Reset clears the sequencer and output valid; config returns to its reset values.
// s_tready is high only in idle; a result waits in the output register while
// the next word is taken, and a finished pixel holds until that register is free.
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_x [9:0], pixel_y [19:10], zero [23:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // iteration_count [15:0], escaped [16], zero [23:17]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t cfg;

    mbe_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t state_reg, state_next;

    logic [9:0]               px_reg, py_reg;
    logic signed [NUM_W-1:0]  c_re_reg, c_im_reg;
    logic signed [NUM_W-1:0]  re_reg, im_reg;
    logic [SQ_W-1:0]          sq_re_reg, sq_im_reg;
    logic [15:0]              count_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     esc_reg;
    logic                     m_valid_reg;
    logic [15:0]              m_count_reg;
    logic                     m_esc_reg;

    logic signed [NUM_W-1:0]  mul_a, mul_b;
    logic signed [11:0]       off_x, off_y;
    logic signed [NUM_W-1:0]  map_center;
    logic signed [MAP_W-1:0]  map_sum;
    logic signed [NUM_W-1:0]  map_sat;
    logic [SQ_W-1:0]          sq_prod;
    logic signed [RI_W-1:0]   ri_prod;
    logic signed [ACC_W-1:0]  nr, ni;
    logic                     nr_fits, ni_fits;
    logic [MAG_W-1:0]         mag;
    logic                     out_free;
    logic                     in_take;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign off_x = $signed({1'b0, px_reg, 1'b0}) - $signed({1'b0, cfg.image_width});
    assign off_y = $signed({1'b0, py_reg, 1'b0}) - $signed({1'b0, cfg.image_height});

    // floor(off*step/2) + centre, saturated to 32 bits
    assign map_center = (state_reg == ST_MAP_IM) ? cfg.center_re : cfg.center_im;
    assign map_sum    = prod_reg[MAP_W:1] + MAP_W'(map_center);
    always_comb
    begin
        if (map_sum[MAP_W-1:NUM_W-1] == '0 || map_sum[MAP_W-1:NUM_W-1] == '1)
            map_sat = map_sum[NUM_W-1:0];
        else if (map_sum[MAP_W-1])
            map_sat = {1'b1, {(NUM_W-1){1'b0}}};
        else
            map_sat = {1'b0, {(NUM_W-1){1'b1}}};
    end

    assign sq_prod = prod_reg[PROD_W-2:FRAC_BITS];
    assign ri_prod = prod_reg[PROD_W-1:FRAC_BITS];

    assign nr = $signed(ACC_W'(sq_re_reg)) - $signed(ACC_W'(sq_im_reg)) + ACC_W'(c_re_reg);
    assign ni = ACC_W'($signed({ri_prod, 1'b0})) + ACC_W'(c_im_reg);
    assign nr_fits = (nr[ACC_W-1:NUM_W-1] == '0) || (nr[ACC_W-1:NUM_W-1] == '1);
    assign ni_fits = (ni[ACC_W-1:NUM_W-1] == '0) || (ni[ACC_W-1:NUM_W-1] == '1);

    assign mag = MAG_W'(sq_re_reg) + MAG_W'(sq_prod);

    always_comb
    begin
        mul_a      = re_reg;
        mul_b      = im_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_MAP_RE;
            end
            ST_MAP_RE:
            begin
                mul_a      = NUM_W'(off_x);
                mul_b      = $signed({1'b0, cfg.pixel_step});
                state_next = ST_MAP_IM;
            end
            ST_MAP_IM:
            begin
                mul_a      = NUM_W'(off_y);
                mul_b      = $signed({1'b0, cfg.pixel_step});
                state_next = ST_MAP_END;
            end
            ST_MAP_END:
                state_next = ST_MUL_RI;
            ST_MUL_RI:
            begin
                if (count_reg >= cfg.iter_limit)
                    state_next = ST_DONE;
                else
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (nr_fits && ni_fits)
                    state_next = ST_SQ_RE;
                else
                    state_next = ST_DONE;
            end
            ST_SQ_RE:
            begin
                mul_a      = re_reg;
                mul_b      = re_reg;
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                mul_a      = im_reg;
                mul_b      = im_reg;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                if (mag > MAG_LIMIT)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL_RI;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_take)
        begin
            px_reg <= s_tdata[9:0];
            py_reg <= s_tdata[19:10];
        end
        unique case (state_reg)
            ST_MAP_IM:
                c_re_reg <= map_sat;
            ST_MAP_END:
            begin
                c_im_reg  <= map_sat;
                re_reg    <= '0;
                im_reg    <= '0;
                sq_re_reg <= '0;
                sq_im_reg <= '0;
                count_reg <= '0;
                esc_reg   <= 1'b0;
            end
            ST_STEP:
            begin
                re_reg <= nr[NUM_W-1:0];
                im_reg <= ni[NUM_W-1:0];
                if (!(nr_fits && ni_fits))
                    esc_reg <= 1'b1;
            end
            ST_SQ_IM:
                sq_re_reg <= sq_prod;
            ST_MAG:
            begin
                sq_im_reg <= sq_prod;
                if (mag > MAG_LIMIT)
                    esc_reg <= 1'b1;
                else
                    count_reg <= count_reg + 16'd1;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            m_count_reg <= count_reg;
            m_esc_reg   <= esc_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_esc_reg, m_count_reg};

endmodule
